FILE: src/dnle_pkg.sv
// Package for the dotted name to label encoder.
// Holds the separator code, default buffer depth and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dnle_pkg;

    // Character that separates labels in the dotted name.
    localparam logic [7:0] SEP_CHAR = 8'h2E;

    // Default depth of the label buffer in characters.
    localparam int DEFAULT_LABEL_DEPTH = 32;

    // Bit positions inside the result tuser.
    localparam int USER_IS_LENGTH = 0;
    localparam int USER_OVERFLOW  = 1;
    localparam int USER_RUN_LAST  = 2;
    localparam int USER_W         = 3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the input word, buffer it if it is a character
        logic load_len;   // load the label length word into the output register
        logic load_char;  // load the next buffered character
        logic load_trail; // load the zero length word of a trailing empty label
        logic mark_last;  // the word loaded now is the last one of this input
    } dnle_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_dot;  // the word on the input is a separator
        logic dot_seen;   // the accepted word was a separator
        logic fin_seen;   // the accepted word was the final character
        logic n_zero;     // the current label is empty
        logic last_char;  // the character to load next is the label's last
        logic out_free;   // the output register can take a word this cycle
    } dnle_status_t;

endpackage

`default_nettype wire

FILE: src/dnle_ctrl.sv
// Controller state machine of the dotted name to label encoder.
// Sequences accept, length word, character words and trailing empty label.
// Depends on dnle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dnle_ctrl
    import dnle_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tlast,
    output logic              s_tready,
    input  wire dnle_status_t status,
    output dnle_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_CHAR,
        ST_TRAIL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   trail_due;

    // A final separator leaves an empty label to close after the current one.
    assign trail_due = status.dot_seen && status.fin_seen;
    assign s_tready  = (state_reg == ST_IDLE);

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (status.in_is_dot || s_tlast) begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                if (status.out_free) begin
                    cmd.load_len  = 1'b1;
                    cmd.mark_last = status.n_zero && !trail_due;
                    if (!status.n_zero) begin
                        state_next = ST_CHAR;
                    end else if (trail_due) begin
                        state_next = ST_TRAIL;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CHAR: begin
                if (status.out_free) begin
                    cmd.load_char = 1'b1;
                    cmd.mark_last = status.last_char && !trail_due;
                    if (status.last_char) begin
                        state_next = trail_due ? ST_TRAIL : ST_IDLE;
                    end
                end
            end
            ST_TRAIL: begin
                if (status.out_free) begin
                    cmd.load_trail = 1'b1;
                    cmd.mark_last  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/dnle_datapath.sv
// Datapath of the dotted name to label encoder: label buffer memory,
// count and overflow flag, read pointer and the output register.
// Depends on dnle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dnle_datapath
    import dnle_pkg::*;
#(
    parameter int LABEL_DEPTH = DEFAULT_LABEL_DEPTH
)(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tlast,
    output logic [7:0]             m_tdata,
    output logic [USER_W-1:0]      m_tuser,
    output logic                   m_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire dnle_cmd_t         cmd,
    output dnle_status_t           status
);

    localparam int IDX_W = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;
    localparam int CNT_W = $clog2(LABEL_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LABEL_DEPTH);

    logic [7:0]       label_mem [LABEL_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;
    logic             dot_reg;
    logic             fin_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_plus;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic             in_is_dot;
    logic             can_store;
    logic             label_done;

    logic [7:0]        out_data_reg;
    logic [USER_W-1:0] out_user_reg;
    logic              out_last_reg;
    logic              out_valid_reg;
    logic              out_load;

    assign in_is_dot = (s_tdata == SEP_CHAR);
    assign can_store = (count_reg < DEPTH_C);
    assign idx_plus  = CNT_W'(idx_reg) + CNT_W'(1);

    // The label is finished once its last word has gone to the output register.
    assign label_done = (cmd.load_len && (count_reg == '0))
                     || (cmd.load_char && (idx_plus == count_reg));

    // Read one character ahead: entry 0 with the length word, then the next one.
    always_comb begin
        rd_en   = cmd.load_len || cmd.load_char;
        rd_addr = '0;
        if (cmd.load_char && (idx_plus < DEPTH_C)) begin
            rd_addr = idx_plus[IDX_W-1:0];
        end
    end

    // Status toward the controller.
    always_comb begin
        status.in_is_dot = in_is_dot;
        status.dot_seen  = dot_reg;
        status.fin_seen  = fin_reg;
        status.n_zero    = (count_reg == '0);
        status.last_char = (idx_plus == count_reg);
        status.out_free  = !out_valid_reg || m_tready;
    end

    // Label buffer memory.
    always_ff @(posedge aclk) begin
        if (cmd.accept && !in_is_dot && can_store) begin
            label_mem[count_reg[IDX_W-1:0]] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= label_mem[rd_addr];
        end
    end

    // Label count, overflow flag and the flags of the accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            dot_reg   <= 1'b0;
            fin_reg   <= 1'b0;
        end else begin
            if (cmd.accept) begin
                dot_reg <= in_is_dot;
                fin_reg <= s_tlast;
                if (!in_is_dot) begin
                    if (can_store) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end
            end else if (label_done) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    // Character pointer within the label being drained.
    always_ff @(posedge aclk) begin
        if (cmd.load_len) begin
            idx_reg <= '0;
        end else if (cmd.load_char) begin
            idx_reg <= idx_plus[IDX_W-1:0];
        end
    end

    // Output register.
    assign out_load = cmd.load_len || cmd.load_char || cmd.load_trail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (cmd.load_len) begin
                out_data_reg <= 8'(count_reg);
            end else if (cmd.load_char) begin
                out_data_reg <= rd_data_reg;
            end else begin
                out_data_reg <= 8'h00;
            end
            out_user_reg[USER_IS_LENGTH] <= !cmd.load_char;
            out_user_reg[USER_OVERFLOW]  <= cmd.load_trail ? 1'b0 : ovf_reg;
            out_user_reg[USER_RUN_LAST]  <= cmd.mark_last;
            out_last_reg                 <= cmd.mark_last && fin_reg;
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

    // The count saturates at the buffer depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("label count above buffer depth");

    // At most one datapath operation per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.load_len, cmd.load_char, cmd.load_trail}))
        else $error("conflicting datapath commands");

    // A trailing empty label is a zero length word that ends the name.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_trail |=> (m_tvalid && m_tlast && (m_tdata == 8'h00)
                            && m_tuser[USER_IS_LENGTH] && m_tuser[USER_RUN_LAST]))
        else $error("trailing empty label word malformed");

    // A word is only loaded when the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("output word overwritten before it was taken");

endmodule

`default_nettype wire

FILE: src/dotted_name_to_label_encoder_core.sv
// Top level of the dotted name to label encoder.
// Joins dnle_ctrl and dnle_datapath; depends on dnle_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes a dotted name one character word at a time (s_tlast on the last one)
// and emits length-prefixed labels, one byte word per cycle while m_tready is
// high. A plain character that is not final is taken without holding the input
// off and gives no output. A separator or the final character holds the input
// off while the label drains through the single output register: first the
// length word, then the buffered characters, and a final separator adds the
// zero length word of its empty label. Labels longer than LABEL_DEPTH are cut
// to LABEL_DEPTH characters with the overflow flag set on all their words.
// m_tlast marks the last word of the name; no terminating zero is added.
module dotted_name_to_label_encoder_core
    import dnle_pkg::*;
#(
    parameter int LABEL_DEPTH = DEFAULT_LABEL_DEPTH
)(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        s_tdata,   // [7:0] in_char
    input  wire logic              s_tlast,   // final_char
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic [7:0]             m_tdata,   // [7:0] out_byte
    output logic [USER_W-1:0]      m_tuser,   // [0] is_length, [1] label_overflow,
                                              // [2] run_last
    output logic                   m_tlast,   // name_end
    output logic                   m_tvalid,
    input  wire logic              m_tready
);

    dnle_cmd_t    cmd;
    dnle_status_t status;

    dnle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dnle_datapath #(
        .LABEL_DEPTH (LABEL_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for dotted_name_to_label_encoder_core.
// Streams dotted names and noise through the block with random stalls on both sides.
// It predicts the length-prefixed words and checks each one; depends on dnle_pkg.
`timescale 1ns / 1ps

module testbench;
    import dnle_pkg::*;

    localparam int DEPTH         = DEFAULT_LABEL_DEPTH;
    localparam int ITEMS         = 450;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 2 * DEPTH + 10;
    localparam int REPORT_LIMIT  = 10;

    logic                aclk;
    logic                aresetn;
    logic [7:0]          s_tdata;
    logic                s_tlast;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          m_tdata;
    logic [USER_W-1:0]   m_tuser;
    logic                m_tlast;
    logic                m_tvalid;
    logic                m_tready;

    // Idling switches, changed by the stimulus process.
    bit src_idle_on;
    bit sink_idle_on;
    int chars_sent;
    int quiet_cycles;

    // One encoded word as the block should produce it.
    typedef struct packed {
        logic [7:0] code;
        logic       is_len;
        logic       ovf;
        logic       run_last;
        logic       name_end;
    } encoded_word_t;

    // Label encoder predictor and the store of words still owed by the block.
    class label_encoding_scoreboard;
        logic [7:0]    held_chars [DEPTH];
        logic [5:0]    held_count;
        logic          overflow_flag;
        encoded_word_t encoded_due [$];
        int            bad_words;

        function new();
            held_count    = '0;
            overflow_flag = 1'b0;
            bad_words     = 0;
        endfunction

        function void push_word(logic [7:0] code, logic is_len, logic ovf);
            encoded_word_t w;
            w.code     = code;
            w.is_len   = is_len;
            w.ovf      = ovf;
            w.run_last = 1'b0;
            w.name_end = 1'b0;
            encoded_due.push_back(w);
        endfunction

        // Length word, then the held characters; the label starts over afterwards.
        function void flush_label();
            logic [5:0] n;
            logic       ovf;
            n   = held_count;
            ovf = overflow_flag;
            push_word({2'b00, n}, 1'b1, ovf);
            for (int i = 0; i < n; i++)
                push_word(held_chars[i], 1'b0, ovf);
            held_count    = '0;
            overflow_flag = 1'b0;
        endfunction

        // Called once per accepted input word.
        function void encode_char(logic [7:0] c, logic fin);
            int start_idx;
            int last_idx;
            start_idx = encoded_due.size();
            if (c == SEP_CHAR) begin
                flush_label();
                // A final separator adds the zero length word of the empty label.
                if (fin)
                    push_word(8'h00, 1'b1, 1'b0);
            end else begin
                if (held_count < DEPTH) begin
                    held_chars[held_count] = c;
                    held_count++;
                end else begin
                    overflow_flag = 1'b1;
                end
                if (fin)
                    flush_label();
            end
            if (encoded_due.size() > start_idx) begin
                last_idx = encoded_due.size() - 1;
                encoded_due[last_idx].run_last = 1'b1;
                if (fin)
                    encoded_due[last_idx].name_end = 1'b1;
            end
        endfunction

        // Compares one accepted output word with the oldest prediction.
        function void check_encoded(logic [7:0] data, logic [USER_W-1:0] user, logic last);
            encoded_word_t w;
            if (encoded_due.size() == 0) begin
                bad_words++;
                if (bad_words <= REPORT_LIMIT)
                    $display("unexpected word: byte %02h user %03b last %0b",
                             data, user, last);
                return;
            end
            w = encoded_due.pop_front();
            if (data !== w.code || user[USER_IS_LENGTH] !== w.is_len
                    || user[USER_OVERFLOW] !== w.ovf || user[USER_RUN_LAST] !== w.run_last
                    || last !== w.name_end) begin
                bad_words++;
                if (bad_words <= REPORT_LIMIT) begin
                    $display("word mismatch: expected byte %02h len %0b ovf %0b run_last %0b end %0b",
                             w.code, w.is_len, w.ovf, w.run_last, w.name_end);
                    $display("               got      byte %02h len %0b ovf %0b run_last %0b end %0b",
                             data, user[USER_IS_LENGTH], user[USER_OVERFLOW],
                             user[USER_RUN_LAST], last);
                end
            end
        endfunction

        function int pending();
            return encoded_due.size();
        endfunction

        function bit clean();
            return bad_words == 0 && encoded_due.size() == 0;
        endfunction
    endclass

    label_encoding_scoreboard sb = new();

    dotted_name_to_label_encoder_core #(
        .LABEL_DEPTH(DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sends one character word, with an occasional gap before it.
    task automatic send_char(input logic [7:0] c, input logic fin);
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tdata  <= c;
        s_tlast  <= fin;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.encode_char(c, fin);
        chars_sent++;
    endtask

    // A well-formed name: random labels, sometimes long, sometimes empty,
    // and now and then a trailing separator.
    task automatic send_name(input bit force_long);
        logic [7:0] chars [$];
        logic [7:0] c;
        int         n_labels;
        int         len;
        n_labels = $urandom_range(1, 4);
        for (int i = 0; i < n_labels; i++) begin
            if (i > 0)
                chars.push_back(SEP_CHAR);
            if (force_long && i == 0)
                len = DEPTH + 1 + $urandom_range(0, 3);
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(DEPTH - 2, DEPTH + 4);
            else
                len = $urandom_range(0, 8);
            for (int j = 0; j < len; j++) begin
                c = $urandom_range(0, 255);
                if (c == SEP_CHAR)
                    c = ~c;
                chars.push_back(c);
            end
        end
        if (chars.size() == 0 || $urandom_range(0, 3) == 0)
            chars.push_back(SEP_CHAR);
        foreach (chars[k])
            send_char(chars[k], k == chars.size() - 1);
    endtask

    // Random characters and stray final marks, separators among them.
    task automatic send_noise();
        logic [7:0] c;
        int         n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(0, 255);
            if ($urandom_range(0, 3) == 0)
                c = SEP_CHAR;
            send_char(c, $urandom_range(0, 3) == 0);
        end
    endtask

    // Stimulus, then drain and verdict.
    initial begin
        aresetn      <= 1'b0;
        s_tdata      <= '0;
        s_tlast      <= 1'b0;
        s_tvalid     <= 1'b0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        chars_sent   = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme character values, a lone final separator,
        // a leading separator, two separators in a row and a trailing one.
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(SEP_CHAR, 1'b0);
        send_char(8'h7F, 1'b1);
        send_char(SEP_CHAR, 1'b1);
        send_char(SEP_CHAR, 1'b0);
        send_char(SEP_CHAR, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(SEP_CHAR, 1'b1);
        send_char(8'h01, 1'b0);
        send_char(8'hFE, 1'b1);

        // Random part; the first name always runs past the buffer depth.
        send_name(1'b1);
        while (chars_sent < ITEMS) begin
            if (chars_sent > ITEMS * 85 / 100) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end else begin
                src_idle_on  = $urandom_range(0, 2) != 0;
                sink_idle_on = $urandom_range(0, 2) != 0;
            end
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_name(1'b0);
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.clean())
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Output side: ready with random stall bursts while idling is enabled.
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Check every accepted output word.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_encoded(m_tdata, m_tuser, m_tlast);
    end

    // Watchdog on cycles where neither side moves a word.
    initial quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

FILE: dotted_name_to_label_encoder_core.f
src/dnle_pkg.sv
src/dnle_ctrl.sv
src/dnle_datapath.sv
src/dotted_name_to_label_encoder_core.sv
sim/testbench.sv
